// ----- rtl/bba_pkg.sv -----
// package for the bitmap block allocator: payload structs, constants, operation and register codes
// no dependencies
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int ID_BITS_DEF    = 16;

    localparam logic [15:0] BLOCK_BYTES_RST = 16'd64;
    localparam logic        FIT_MODE_RST    = 1'b1;

    localparam logic [0:0] CFG_BLOCK_BYTES = 1'b0;
    localparam logic [0:0] CFG_FIT_MODE    = 1'b1;

    localparam logic OP_FREE  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] owner_id;
        logic [23:0] size_bytes;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [9:0]  start_block;
        logic [10:0] blocks_changed;
        logic [25:0] bytes_in_use;
    } t_out_item;

endpackage

// ----- rtl/bba_ram.sv -----
// generic single-port-write, single-port-read synchronous ram, registered read
// no dependencies
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/bitmap_block_allocator_core.sv -----
// Bitmap block allocator. After reset a clearing pass over every block zeroes
// the used map, during which no item transfer is taken. An allocate item first
// turns its size into a block count with a restoring divider, then scans the
// used map one block per cycle (a first-fit search covers at most NUM_BLOCKS
// blocks; for next fit the two passes together cover at most NUM_BLOCKS+1
// blocks), then writes the found run one block per cycle. A free item scans
// every block once and clears matching ones, one block per cycle. A new item
// is taken only after the result transfer of the previous one.
// depends on bba_pkg and bba_ram
module bitmap_block_allocator_core #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int ID_BITS    = bba_pkg::ID_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  bba_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output bba_pkg::t_out_item o_item
);
    import bba_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int CW = AW + 1;
    localparam int DW = 24;
    localparam int MW = 1 + ID_BITS;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_CLAIM = 7'b0010000,
        S_FREE  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_block_bytes;
    logic        r_fit_mode;

    logic                r_op;
    logic [ID_BITS-1:0]  r_id;
    logic [15:0]         r_bb;
    logic [DW-1:0]       r_quot;
    logic [16:0]         r_rem;
    logic [4:0]          r_dcnt;
    logic                r_round;
    logic [CW-1:0]       r_addr;
    logic [CW-1:0]       r_to;
    logic                r_wrap;
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_addr;
    logic [DW:0]         r_count;
    logic [DW:0]         r_need;
    logic [AW-1:0]       r_last;
    logic [CW-1:0]       r_changed;
    logic [CW-1:0]       r_next_start;
    logic [47:0]         r_alloc_tot;
    logic [47:0]         r_rel_tot;
    logic                r_o_valid;
    t_out_item           r_out;

    // memory port signals
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [MW-1:0]     w_wdata;
    logic [MW-1:0]     w_rdata;

    bba_ram #(.WIDTH(MW), .DEPTH(NUM_BLOCKS)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    logic [15:0] w_eff_bb;
    assign w_eff_bb = (r_block_bytes == 16'd0) ? 16'd1 : r_block_bytes;

    // input taken only when idle and no result waits
    logic w_in_xfer;
    assign o_ready   = (r_state == S_IDLE) && !r_o_valid;
    assign w_in_xfer = i_valid && o_ready;
    assign o_valid   = r_o_valid;
    assign o_item    = r_out;

    // divider step
    logic [16:0] w_rem_sh;
    logic        w_ge;
    assign w_rem_sh = {r_rem[15:0], r_quot[DW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_bb});

    // scan helpers: read data valid for block r_rd_addr
    logic        w_used;
    logic        w_match;
    logic [DW:0] w_cnt_nx;
    assign w_used   = w_rdata[MW-1];
    assign w_match  = w_used && (w_rdata[ID_BITS-1:0] == r_id);
    assign w_cnt_nx = w_used ? '0 : r_count + 1'b1;

    // end of scan and free walks
    logic w_scan_hit;
    logic w_scan_end;
    logic w_free_end;
    assign w_scan_hit = r_rd_vld && !w_used && (w_cnt_nx == r_need);
    assign w_scan_end = !r_rd_vld && !(r_addr < r_to);
    assign w_free_end = !r_rd_vld && !(r_addr < CW'(NUM_BLOCKS));

    logic [47:0] w_bb48;
    assign w_bb48 = {32'd0, r_bb};

    logic [CW-1:0] w_start;
    assign w_start = CW'(r_last) + 1'b1 - r_need[CW-1:0];

    // memory write selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr[AW-1:0];
        w_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_CLAIM: begin
                w_we    = 1'b1;
                w_wdata = {1'b1, r_id};
            end
            S_FREE: begin
                w_we    = r_rd_vld && w_match;
                w_waddr = r_rd_addr;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_addr == CW'(NUM_BLOCKS - 1)) n_state = S_IDLE;
            S_IDLE:  if (w_in_xfer) n_state = (i_item.operation == OP_ALLOC) ? S_DIV : S_FREE;
            S_DIV:   if (r_dcnt == 5'd0 && r_round) n_state = S_SCAN;
            S_SCAN: begin
                if (w_scan_hit) n_state = S_CLAIM;
                else if (w_scan_end && r_wrap) n_state = S_DONE;
            end
            S_CLAIM: if (r_changed == r_need[CW-1:0] - 1'b1) n_state = S_DONE;
            S_FREE:  if (w_free_end) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_addr        <= '0;
            r_block_bytes <= BLOCK_BYTES_RST;
            r_fit_mode    <= FIT_MODE_RST;
            r_next_start  <= '0;
            r_alloc_tot   <= '0;
            r_rel_tot     <= '0;
            r_o_valid     <= 1'b0;
            r_rd_vld      <= 1'b0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data;
                    CFG_FIT_MODE:    r_fit_mode    <= i_cfg_data[0];
                    default:         r_fit_mode    <= r_fit_mode;
                endcase
            end
            // output transfer
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_addr <= (r_addr == CW'(NUM_BLOCKS - 1)) ? '0 : r_addr + 1'b1;
                end
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_op    <= i_item.operation;
                        r_id    <= i_item.owner_id[ID_BITS-1:0];
                        r_bb    <= w_eff_bb;
                        r_quot  <= ({8'd0, w_eff_bb} > i_item.size_bytes) ?
                                   {8'd0, w_eff_bb} : i_item.size_bytes;
                        r_rem   <= '0;
                        r_dcnt  <= 5'(DW);
                        r_round <= 1'b0;
                        r_addr  <= '0;
                        r_rd_vld <= 1'b0;
                        r_changed <= '0;
                        r_count <= '0;
                        r_wrap  <= 1'b0;
                    end
                end
                S_DIV: begin
                    if (r_dcnt != 5'd0) begin
                        r_rem  <= w_ge ? w_rem_sh - {1'b0, r_bb} : w_rem_sh;
                        r_quot <= {r_quot[DW-2:0], w_ge};
                        r_dcnt <= r_dcnt - 1'b1;
                    end else begin
                        // ceiling and scan range
                        r_need  <= {1'b0, r_quot} + ((r_rem != 17'd0) ? 25'd1 : 25'd0);
                        r_round <= 1'b1;
                        if (r_fit_mode) begin
                            r_addr <= '0;
                            r_to   <= CW'(NUM_BLOCKS);
                            r_wrap <= 1'b1;
                        end else begin
                            r_addr <= r_next_start;
                            r_to   <= CW'(NUM_BLOCKS);
                            r_wrap <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_scan_hit) begin
                        // run found, claim from its first block
                        r_last   <= r_rd_addr;
                        r_rd_vld <= 1'b0;
                        r_addr   <= CW'(r_rd_addr) + 1'b1 - r_need[CW-1:0];
                        if (!r_fit_mode) r_next_start <= CW'(r_rd_addr) + 1'b1;
                    end else if (w_scan_end) begin
                        if (!r_wrap) begin
                            r_wrap  <= 1'b1;
                            r_count <= '0;
                            r_addr  <= '0;
                            r_to    <= (r_next_start >= CW'(NUM_BLOCKS)) ?
                                       CW'(NUM_BLOCKS) : r_next_start + 1'b1;
                        end else begin
                            r_out.ok             <= 1'b0;
                            r_out.start_block    <= '0;
                            r_out.blocks_changed <= '0;
                            r_out.bytes_in_use   <= 26'(r_alloc_tot - r_rel_tot);
                        end
                    end else begin
                        // issue read, evaluate previous
                        if (r_addr < r_to) begin
                            r_rd_vld  <= 1'b1;
                            r_rd_addr <= r_addr[AW-1:0];
                            r_addr    <= r_addr + 1'b1;
                        end else begin
                            r_rd_vld <= 1'b0;
                        end
                        if (r_rd_vld) begin
                            r_count <= w_cnt_nx;
                        end
                    end
                end
                S_CLAIM: begin
                    r_addr      <= r_addr + 1'b1;
                    r_changed   <= r_changed + 1'b1;
                    r_alloc_tot <= r_alloc_tot + w_bb48;
                    if (r_changed == r_need[CW-1:0] - 1'b1) begin
                        r_out.ok             <= 1'b1;
                        r_out.start_block    <= 10'(w_start);
                        r_out.blocks_changed <= 11'(r_need);
                        r_out.bytes_in_use   <= 26'(r_alloc_tot + w_bb48 - r_rel_tot);
                    end
                end
                S_FREE: begin
                    if (r_addr < CW'(NUM_BLOCKS)) begin
                        r_rd_vld  <= 1'b1;
                        r_rd_addr <= r_addr[AW-1:0];
                        r_addr    <= r_addr + 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld && w_match) begin
                        r_changed <= r_changed + 1'b1;
                        r_rel_tot <= r_rel_tot + w_bb48;
                    end
                    if (w_free_end) begin
                        r_out.ok             <= 1'b1;
                        r_out.start_block    <= '0;
                        r_out.blocks_changed <= 11'(r_changed);
                        r_out.bytes_in_use   <= 26'(r_alloc_tot - r_rel_tot);
                    end
                end
                S_DONE: begin
                    r_o_valid <= 1'b1;
                end
                default: begin
                    r_rd_vld <= 1'b0;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // no input transfer while busy or while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE || r_o_valid) |-> !o_ready)
        else $error("ready while busy");
    // a run never claimed beyond the table
    a_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAIM) |-> (r_addr < CW'(NUM_BLOCKS)))
        else $error("claim out of range");
    // a free result always reports success
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_op == OP_FREE) |-> r_out.ok)
        else $error("free not ok");
`endif
endmodule

// ----- tb/bitmap_block_allocator_core_tb.sv -----
// testbench for bitmap_block_allocator_core: directed items, then random allocate/free traffic
// depends on bba_pkg and the allocator rtl; checks every result against a local allocator model
`timescale 1ns / 100ps

module bitmap_block_allocator_core_tb;
    import bba_pkg::*;

    localparam int NBLK = 1024;
    localparam int N_RANDOM = 520;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [15:0] i_cfg_data;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    bitmap_block_allocator_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    // allocator model state
    logic        mdl_used [NBLK];
    logic [15:0] mdl_owner [NBLK];
    logic [10:0] mdl_next;
    logic [47:0] mdl_alloc_tot;
    logic [47:0] mdl_rel_tot;
    logic [15:0] mdl_block_bytes;
    logic        mdl_fit_first;

    t_out_item   pending_results [$];
    int          n_fail;
    int          n_mismatch;

    // directed table
    typedef struct {
        t_in_item  item;
        bit        has_exp;
        t_out_item exp;
    } t_dir_row;
    t_dir_row dir_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("FAIL bitmap_block_allocator_core");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // scan [from, to) for n free blocks, returns last block or -1
    function automatic int find_run(int from, int to, longint n);
        longint cnt;
        cnt = 0;
        for (int i = from; i < to; i++) begin
            if (!mdl_used[i]) begin
                cnt++;
                if (cnt == n) return i;
            end else begin
                cnt = 0;
            end
        end
        return -1;
    endfunction

    function automatic t_out_item predict_alloc(t_in_item it);
        t_out_item r;
        longint bb, sz, n;
        int last, from, upto;
        bb = (mdl_block_bytes == 0) ? 1 : mdl_block_bytes;
        r = '0;
        if (it.operation == OP_ALLOC) begin
            sz = it.size_bytes;
            if (sz < bb) sz = bb;
            n = (sz + bb - 1) / bb;
            if (mdl_fit_first) begin
                last = find_run(0, NBLK, n);
            end else begin
                from = (mdl_next < NBLK) ? int'(mdl_next) : NBLK;
                last = find_run(from, NBLK, n);
                if (last < 0) begin
                    upto = int'(mdl_next) + 1;
                    if (upto > NBLK) upto = NBLK;
                    last = find_run(0, upto, n);
                end
                if (last >= 0) mdl_next = 11'(last + 1);
            end
            if (last >= 0) begin
                for (int j = last + 1 - int'(n); j <= last; j++) begin
                    mdl_used[j] = 1'b1;
                    mdl_owner[j] = it.owner_id;
                    mdl_alloc_tot = mdl_alloc_tot + 48'(bb);
                end
                r.ok = 1'b1;
                r.start_block = 10'(last + 1 - int'(n));
                r.blocks_changed = 11'(n);
            end
        end else begin
            for (int i = 0; i < NBLK; i++) begin
                if (mdl_used[i] && mdl_owner[i] == it.owner_id) begin
                    mdl_used[i] = 1'b0;
                    mdl_rel_tot = mdl_rel_tot + 48'(bb);
                    r.blocks_changed = r.blocks_changed + 11'd1;
                end
            end
            r.ok = 1'b1;
        end
        r.bytes_in_use = 26'(mdl_alloc_tot - mdl_rel_tot);
        return r;
    endfunction

    function automatic t_in_item mk_item(logic op, logic [15:0] id, logic [23:0] sz);
        t_in_item it;
        it.operation = op;
        it.owner_id = id;
        it.size_bytes = sz;
        return it;
    endfunction

    function automatic t_out_item mk_res(logic ok, int sb, int ch, int biu);
        t_out_item r;
        r.ok = ok;
        r.start_block = 10'(sb);
        r.blocks_changed = 11'(ch);
        r.bytes_in_use = 26'(biu);
        return r;
    endfunction

    task automatic add_row(t_in_item it, bit has_exp, t_out_item ex);
        t_dir_row row;
        row.item = it;
        row.has_exp = has_exp;
        row.exp = ex;
        dir_rows.push_back(row);
    endtask

    // one input transfer, expectation queued at acceptance
    task automatic send_item(t_in_item it, bit has_exp, t_out_item ex);
        t_out_item pred;
        int g;
        g = gap_len();
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = predict_alloc(it);
        if (has_exp && pred !== ex) begin
            n_fail++;
            $display("table row disagrees with model: table %h model %h", ex, pred);
        end
        pending_results.push_back(pred);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BLOCK_BYTES) mdl_block_bytes = val;
        else mdl_fit_first = val[0];
        @(posedge i_clk);
    endtask

    // result side: random stalls, compare with oldest expectation
    initial begin
        t_out_item ex;
        int stall;
        int g;
        stall = 0;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    n_fail++;
                    if (n_mismatch++ < 10) $display("unexpected result %h", o_item);
                end else begin
                    ex = pending_results.pop_front();
                    if (o_item !== ex) begin
                        n_fail++;
                        if (n_mismatch++ < 10)
                            $display({"mismatch exp ok=%0d sb=%0d ch=%0d biu=%0d",
                                      " act ok=%0d sb=%0d ch=%0d biu=%0d"},
                                ex.ok, ex.start_block, ex.blocks_changed, ex.bytes_in_use,
                                o_item.ok, o_item.start_block, o_item.blocks_changed,
                                o_item.bytes_in_use);
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    stall = g - 1;
                    i_ready <= 1'b0;
                end
            end
        end
    end

    // main stimulus
    initial begin
        t_in_item it;
        int r;
        logic [15:0] id;
        n_fail = 0;
        n_mismatch = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_item = '0;
        for (int i = 0; i < NBLK; i++) begin
            mdl_used[i] = 1'b0;
            mdl_owner[i] = '0;
        end
        mdl_next = '0;
        mdl_alloc_tot = '0;
        mdl_rel_tot = '0;
        mdl_block_bytes = BLOCK_BYTES_RST;
        mdl_fit_first = FIT_MODE_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: 64-byte blocks, first fit
        add_row(mk_item(OP_ALLOC, 16'h0001, 24'd0), 1, mk_res(1, 0, 1, 64));
        add_row(mk_item(OP_ALLOC, 16'hFFFF, 24'd65), 1, mk_res(1, 1, 2, 192));
        add_row(mk_item(OP_FREE, 16'h1234, 24'hFFFFFF), 1, mk_res(1, 0, 0, 192));
        add_row(mk_item(OP_ALLOC, 16'h0002, 24'hFFFFFF), 1, mk_res(0, 0, 0, 192));
        add_row(mk_item(OP_FREE, 16'h0001, 24'd0), 1, mk_res(1, 0, 1, 128));
        add_row(mk_item(OP_ALLOC, 16'h0003, 24'd64), 1, mk_res(1, 0, 1, 192));
        add_row(mk_item(OP_ALLOC, 16'h0004, 24'd65344), 1, mk_res(1, 3, 1021, 65536));
        add_row(mk_item(OP_ALLOC, 16'h0005, 24'd1), 1, mk_res(0, 0, 0, 65536));
        add_row(mk_item(OP_FREE, 16'h0004, 24'd0), 1, mk_res(1, 0, 1021, 192));
        add_row(mk_item(OP_FREE, 16'hFFFF, 24'd0), 1, mk_res(1, 0, 2, 64));
        add_row(mk_item(OP_FREE, 16'h0003, 24'd0), 1, mk_res(1, 0, 1, 0));
        add_row(mk_item(OP_ALLOC, 16'h0000, 24'd65536), 1, mk_res(1, 0, 1024, 65536));
        add_row(mk_item(OP_FREE, 16'h0000, 24'd0), 1, mk_res(1, 0, 1024, 0));
        foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].has_exp, dir_rows[k].exp);
        wait_drained();

        // next fit with zero block size, then the largest block size
        write_reg(CFG_FIT_MODE, 16'd0);
        write_reg(CFG_BLOCK_BYTES, 16'd0);
        send_item(mk_item(OP_ALLOC, 16'h0010, 24'd300), 0, '0);
        send_item(mk_item(OP_ALLOC, 16'h0011, 24'd700), 0, '0);
        send_item(mk_item(OP_ALLOC, 16'h0012, 24'd100), 0, '0);
        send_item(mk_item(OP_FREE, 16'h0010, 24'd0), 0, '0);
        send_item(mk_item(OP_ALLOC, 16'h0013, 24'd200), 0, '0);
        send_item(mk_item(OP_ALLOC, 16'h0014, 24'd24), 0, '0);
        wait_drained();
        write_reg(CFG_BLOCK_BYTES, 16'hFFFF);
        send_item(mk_item(OP_ALLOC, 16'h0015, 24'hFFFFFF), 0, '0);
        send_item(mk_item(OP_FREE, 16'h0011, 24'd0), 0, '0);
        wait_drained();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: write_reg(CFG_BLOCK_BYTES, 16'(1 << $urandom_range(0, 15)));
                1: write_reg(CFG_BLOCK_BYTES, 16'($urandom_range(1, 65535)));
                2: write_reg(CFG_BLOCK_BYTES, 16'd1);
                default: write_reg(CFG_BLOCK_BYTES, 16'hFFFF);
            endcase
            write_reg(CFG_FIT_MODE, 16'($urandom_range(0, 1)));
            for (int k = 0; k < N_RANDOM / 8; k++) begin
                r = $urandom_range(0, 99);
                id = (r < 90) ? 16'($urandom_range(0, 15)) : 16'($urandom);
                if (r < 60) begin
                    it = mk_item(OP_ALLOC, id,
                        ($urandom_range(0, 9) == 0) ? 24'($urandom) :
                        24'($urandom_range(0, 40) * (mdl_block_bytes == 0 ? 1 : mdl_block_bytes)
                            + $urandom_range(0, 3)));
                end else begin
                    it = mk_item(OP_FREE, id, 24'($urandom));
                end
                send_item(it, 0, '0);
                if (k == 30) wait_drained();
            end
            wait_drained();
        end

        if (n_fail == 0 && pending_results.size() == 0) begin
            $display("PASS bitmap_block_allocator_core");
        end else begin
            $display("FAIL bitmap_block_allocator_core");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bitmap_block_allocator_core.sv
tb/bitmap_block_allocator_core_tb.sv
